// ===== hw/rtl/mp3_frame_header_finder_top_macros.svh =====
// ----------------------------------------------------------------------------
// MP3 frame header finder assertion macros
// Shared property wrappers for the checker attached to the top level.
// ----------------------------------------------------------------------------
`ifndef MP3_FRAME_HEADER_FINDER_TOP_MACROS_SVH
`define MP3_FRAME_HEADER_FINDER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MP3FHF_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MP3FHF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define MP3FHF_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mp3fhf_pkg.sv =====
// ----------------------------------------------------------------------------
// MP3 frame header finder package
// Types, codes, constants and lookup tables shared by the finder's modules.
// ----------------------------------------------------------------------------
package mp3fhf_pkg;

   localparam int POSITION_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH            = 2;
   localparam int DIVIDEND_WIDTH         = 29;
   localparam int DIV_STEPS              = DIVIDEND_WIDTH;

   localparam logic [7:0] SYNC_BYTE  = 8'hFF;
   localparam logic [2:0] SYNC_BITS  = 3'h7;
   localparam logic [7:0] ID3_CHAR_I = 8'h49;
   localparam logic [7:0] ID3_CHAR_D = 8'h44;
   localparam logic [7:0] ID3_CHAR_3 = 8'h33;
   localparam logic [29:0] TAG_HEADER_BYTES = 30'd10;

   localparam logic [1:0] VERSION_BITS_MPEG1 = 2'b11;
   localparam logic [1:0] VERSION_BITS_MPEG2 = 2'b10;
   localparam logic [1:0] LAYER_BITS_LAYER3  = 2'b01;
   localparam logic [1:0] RATE_INDEX_RESERVED = 2'b11;
   localparam logic [1:0] MODE_MONO          = 2'b11;

   localparam logic [1:0] VERSION_NONE  = 2'd0;
   localparam logic [1:0] VERSION_MPEG1 = 2'd1;
   localparam logic [1:0] VERSION_MPEG2 = 2'd2;

   localparam logic [10:0] SAMPLES_MPEG1 = 11'd1152;
   localparam logic [10:0] SAMPLES_MPEG2 = 11'd576;
   localparam logic [9:0]  KBPS_SCALE    = 10'd1000;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_BAD_VERSION = 3'd1,
      STATUS_NOT_LAYER3  = 3'd2,
      STATUS_BAD_RATE    = 3'd3,
      STATUS_NO_SYNC     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PHASE_TAG_CHECK,
      PHASE_TAG_HEADER,
      PHASE_SCAN,
      PHASE_DONE
   } phase_type;

   typedef enum logic {
      ENTRY_HEADER,
      ENTRY_NO_SYNC
   } entry_kind_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_DECODE,
      BACK_MUL_RATE,
      BACK_MUL_SAMPLES,
      BACK_DIVIDE,
      BACK_FRAME,
      BACK_DONE
   } back_state_type;

   typedef struct packed {
      entry_kind_type kind;
      logic [23:0]    hdr_bytes;
      logic [29:0]    tag_bytes;
      logic [31:0]    position;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      status_type  status;
      logic [1:0]  mpeg_version;
      logic [8:0]  bitrate_kbps;
      logic [15:0] sample_rate_hz;
      logic [1:0]  channel_count;
      logic        padding_bit;
      logic [10:0] frame_bytes;
      logic [15:0] avg_bytes_per_sec;
      logic [29:0] tag_bytes;
      logic [31:0] header_position;
   } result_type;

   function automatic logic [8:0] bitrate_lookup(input logic is_mpeg2,
                                                 input logic [3:0] index);
      logic [8:0] kbps;
      if (!is_mpeg2) begin
         unique case (index)
            4'd1:    kbps = 9'd32;
            4'd2:    kbps = 9'd40;
            4'd3:    kbps = 9'd48;
            4'd4:    kbps = 9'd56;
            4'd5:    kbps = 9'd64;
            4'd6:    kbps = 9'd80;
            4'd7:    kbps = 9'd96;
            4'd8:    kbps = 9'd112;
            4'd9:    kbps = 9'd128;
            4'd10:   kbps = 9'd160;
            4'd11:   kbps = 9'd192;
            4'd12:   kbps = 9'd224;
            4'd13:   kbps = 9'd256;
            4'd14:   kbps = 9'd320;
            default: kbps = 9'd0;
         endcase
      end else begin
         unique case (index)
            4'd1:    kbps = 9'd8;
            4'd2:    kbps = 9'd16;
            4'd3:    kbps = 9'd24;
            4'd4:    kbps = 9'd32;
            4'd5:    kbps = 9'd40;
            4'd6:    kbps = 9'd48;
            4'd7:    kbps = 9'd56;
            4'd8:    kbps = 9'd64;
            4'd9:    kbps = 9'd80;
            4'd10:   kbps = 9'd96;
            4'd11:   kbps = 9'd112;
            4'd12:   kbps = 9'd128;
            4'd13:   kbps = 9'd144;
            4'd14:   kbps = 9'd160;
            default: kbps = 9'd0;
         endcase
      end
      return kbps;
   endfunction

   function automatic logic [15:0] rate_lookup(input logic is_mpeg2,
                                               input logic [1:0] index);
      logic [15:0] hz;
      unique case (index)
         2'd0:    hz = is_mpeg2 ? 16'd22050 : 16'd44100;
         2'd1:    hz = is_mpeg2 ? 16'd24000 : 16'd48000;
         2'd2:    hz = is_mpeg2 ? 16'd16000 : 16'd32000;
         default: hz = 16'd0;
      endcase
      return hz;
   endfunction

endpackage

// ===== hw/rtl/mp3fhf_if.sv =====
// ----------------------------------------------------------------------------
// MP3 frame header finder channels
// Valid/ready channels for the byte stream and for the header results.
// ----------------------------------------------------------------------------
interface mp3fhf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_start;
   logic       stream_end;

   modport source (output valid, data_byte, stream_start, stream_end, input ready);
   modport sink   (input valid, data_byte, stream_start, stream_end, output ready);
endinterface

interface mp3fhf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [1:0]  mpeg_version;
   logic [8:0]  bitrate_kbps;
   logic [15:0] sample_rate_hz;
   logic [1:0]  channel_count;
   logic        padding_bit;
   logic [10:0] frame_bytes;
   logic [15:0] avg_bytes_per_sec;
   logic [29:0] tag_bytes;
   logic [31:0] header_position;

   modport source (output valid, status, mpeg_version, bitrate_kbps, sample_rate_hz,
                   channel_count, padding_bit, frame_bytes, avg_bytes_per_sec,
                   tag_bytes, header_position, input ready);
   modport sink   (input valid, status, mpeg_version, bitrate_kbps, sample_rate_hz,
                   channel_count, padding_bit, frame_bytes, avg_bytes_per_sec,
                   tag_bytes, header_position, output ready);
endinterface

// ===== hw/rtl/mp3fhf_scan.sv =====
// ----------------------------------------------------------------------------
// MP3 frame header finder byte scanner
// Tracks the tag header and the sliding window; queues a found header or a
// missing-sync notice for the decoder.
// ----------------------------------------------------------------------------
module mp3fhf_scan #(
   parameter int POSITION_WIDTH = mp3fhf_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_accept,
   input  logic [7:0]            data_byte,
   input  logic                  stream_start,
   input  logic                  stream_end,
   output logic                  push,
   output mp3fhf_pkg::entry_type push_entry
);
   import mp3fhf_pkg::*;

   localparam int CW = (POSITION_WIDTH > 31) ? POSITION_WIDTH : 31;

   logic [23:0]               window_ff, window_in;
   logic [POSITION_WIDTH-1:0] count_ff, count_in;
   phase_type                 phase_ff, phase_in;
   logic [29:0]               tag_ff, tag_in;
   logic                      reported_ff, reported_in;

   // State as seen by this byte: a start byte sees the cleared state.
   logic [23:0]               cur_window;
   logic [POSITION_WIDTH-1:0] cur_count;
   phase_type                 cur_phase;
   logic [29:0]               cur_tag;
   logic                      cur_reported;

   logic                      is_id3;
   logic                      at_magic_end;
   logic                      tag_header_done;
   logic                      sync_hit;
   logic                      emit_header;
   logic                      emit_end;
   logic                      reaches_scan;
   logic [29:0]               size_part;
   logic [29:0]               tag_step;
   logic [POSITION_WIDTH-1:0] hdr_position;

   assign cur_window   = stream_start ? '0 : window_ff;
   assign cur_count    = stream_start ? '0 : count_ff;
   assign cur_phase    = stream_start ? PHASE_TAG_CHECK : phase_ff;
   assign cur_tag      = stream_start ? '0 : tag_ff;
   assign cur_reported = stream_start ? 1'b0 : reported_ff;

   assign is_id3 = (cur_window[15:8] == ID3_CHAR_I) && (cur_window[7:0] == ID3_CHAR_D) &&
                   (data_byte == ID3_CHAR_3);
   assign at_magic_end    = (cur_count == POSITION_WIDTH'(2));
   assign tag_header_done = (cur_count >= POSITION_WIDTH'(9));
   assign sync_hit = (CW'(cur_count) >= CW'(cur_tag) + CW'(3)) &&
                     (cur_window[23:16] == SYNC_BYTE) && (cur_window[15:13] == SYNC_BITS);

   assign emit_header = !cur_reported && (cur_phase == PHASE_SCAN) && sync_hit;
   assign emit_end    = !cur_reported && stream_end && !emit_header;

   // Size bytes six to nine of the tag header carry 7-bit groups, top group first.
   always_comb begin
      priority if (cur_count == POSITION_WIDTH'(6)) size_part = 30'(data_byte) << 21;
      else if (cur_count == POSITION_WIDTH'(7))     size_part = 30'(data_byte) << 14;
      else if (cur_count == POSITION_WIDTH'(8))     size_part = 30'(data_byte) << 7;
      else if (cur_count == POSITION_WIDTH'(9))     size_part = 30'(data_byte);
      else                                          size_part = '0;
   end

   always_comb begin
      tag_step = cur_tag;
      if (cur_phase == PHASE_TAG_CHECK && at_magic_end && !is_id3) begin
         tag_step = '0;
      end else if (cur_phase == PHASE_TAG_HEADER) begin
         tag_step = tag_header_done ? ((cur_tag | size_part) + TAG_HEADER_BYTES)
                                    : (cur_tag | size_part);
      end
   end

   assign reaches_scan = (cur_phase == PHASE_SCAN) || (cur_phase == PHASE_DONE) ||
                         (cur_phase == PHASE_TAG_CHECK && at_magic_end && !is_id3) ||
                         (cur_phase == PHASE_TAG_HEADER && tag_header_done);

   assign hdr_position = cur_count - POSITION_WIDTH'(3);

   // Next phase and report flag.
   always_comb begin
      phase_in    = phase_ff;
      reported_in = reported_ff;
      if (in_accept) begin
         phase_in    = cur_phase;
         reported_in = cur_reported;
         if (!cur_reported) begin
            unique case (cur_phase)
               PHASE_TAG_CHECK: begin
                  if (at_magic_end) phase_in = is_id3 ? PHASE_TAG_HEADER : PHASE_SCAN;
               end
               PHASE_TAG_HEADER: begin
                  if (tag_header_done) phase_in = PHASE_SCAN;
               end
               PHASE_SCAN: begin
                  if (sync_hit) phase_in = PHASE_DONE;
               end
               PHASE_DONE: begin
                  phase_in = PHASE_DONE;
               end
            endcase
            if (emit_end) phase_in = PHASE_DONE;
            if (emit_header || emit_end) reported_in = 1'b1;
         end
      end
   end

   // Window, position, tag size and queue writes.
   always_comb begin
      window_in  = window_ff;
      count_in   = count_ff;
      tag_in     = tag_ff;
      push       = 1'b0;
      push_entry = '{kind: ENTRY_HEADER, hdr_bytes: {cur_window[15:0], data_byte},
                     tag_bytes: cur_tag, position: 32'(hdr_position)};
      if (in_accept) begin
         window_in = cur_window;
         count_in  = cur_count;
         tag_in    = cur_tag;
         if (!cur_reported) begin
            window_in = {cur_window[15:0], data_byte};
            count_in  = (cur_count == '1) ? cur_count : cur_count + POSITION_WIDTH'(1);
            tag_in    = tag_step;
            if (emit_header) begin
               push = 1'b1;
            end else if (emit_end) begin
               push       = 1'b1;
               push_entry = '{kind: ENTRY_NO_SYNC, hdr_bytes: '0,
                              tag_bytes: reaches_scan ? tag_step : '0, position: '0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         count_ff    <= '0;
         phase_ff    <= PHASE_TAG_CHECK;
         tag_ff      <= '0;
         reported_ff <= 1'b0;
      end else begin
         window_ff   <= window_in;
         count_ff    <= count_in;
         phase_ff    <= phase_in;
         tag_ff      <= tag_in;
         reported_ff <= reported_in;
      end
   end

endmodule

// ===== hw/rtl/mp3fhf_queue.sv =====
// ----------------------------------------------------------------------------
// MP3 frame header finder queue
// Small first-in first-out buffer between the scanner and the decoder.
// ----------------------------------------------------------------------------
module mp3fhf_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  mp3fhf_pkg::entry_type        push_entry,
   input  logic                         pop,
   output mp3fhf_pkg::entry_type        pop_entry,
   output mp3fhf_pkg::queue_status_type queue_status
);
   import mp3fhf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign queue_status.full  = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_status.empty = (fill_ff == '0);
   assign do_push   = push && !queue_status.full;
   assign do_pop    = pop && !queue_status.empty;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) fill_in = fill_ff + CNT_W'(1);
      else if (do_pop && !do_push) fill_in = fill_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== hw/rtl/mp3fhf_decode.sv =====
// ----------------------------------------------------------------------------
// MP3 frame header finder decoder
// Decodes one queued header: table lookups, two multiplies and a bit-serial
// divide for the frame length; holds the result until it is taken.
// ----------------------------------------------------------------------------
module mp3fhf_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   entry_valid,
   input  mp3fhf_pkg::entry_type  entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mp3fhf_pkg::result_type result
);
   import mp3fhf_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS);

   back_state_type            state_ff, state_in;
   entry_type                 entry_ff;
   result_type                result_ff;
   logic [18:0]               rate_prod_ff;
   logic [DIVIDEND_WIDTH-1:0] dividend_ff;
   logic [15:0]               rem_ff;
   logic [STEP_W-1:0]         step_ff;

   logic [7:0]  b1, b2, b3;
   logic        is_mpeg2;
   status_type  status_c;
   result_type  decoded_c;
   logic [16:0] rem_shift;
   logic [17:0] trial;
   logic [10:0] samples;

   assign b1 = entry_ff.hdr_bytes[23:16];
   assign b2 = entry_ff.hdr_bytes[15:8];
   assign b3 = entry_ff.hdr_bytes[7:0];
   assign is_mpeg2 = (b1[4:3] == VERSION_BITS_MPEG2);

   always_comb begin
      priority if (entry_ff.kind == ENTRY_NO_SYNC) status_c = STATUS_NO_SYNC;
      else if (b1[4:3] != VERSION_BITS_MPEG1 && b1[4:3] != VERSION_BITS_MPEG2)
         status_c = STATUS_BAD_VERSION;
      else if (b1[2:1] != LAYER_BITS_LAYER3) status_c = STATUS_NOT_LAYER3;
      else if (b2[3:2] == RATE_INDEX_RESERVED) status_c = STATUS_BAD_RATE;
      else status_c = STATUS_OK;
   end

   // Fields known right after the table lookups; the rest follow later.
   always_comb begin
      decoded_c                 = '0;
      decoded_c.status          = status_c;
      decoded_c.tag_bytes       = entry_ff.tag_bytes;
      decoded_c.header_position = entry_ff.position;
      if (status_c == STATUS_OK) begin
         decoded_c.mpeg_version   = is_mpeg2 ? VERSION_MPEG2 : VERSION_MPEG1;
         decoded_c.bitrate_kbps   = bitrate_lookup(is_mpeg2, b2[7:4]);
         decoded_c.sample_rate_hz = rate_lookup(is_mpeg2, b2[3:2]);
         decoded_c.channel_count  = (b3[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
         decoded_c.padding_bit    = b2[1];
      end
   end

   assign samples   = (result_ff.mpeg_version == VERSION_MPEG1) ? SAMPLES_MPEG1 : SAMPLES_MPEG2;
   assign rem_shift = {rem_ff, dividend_ff[DIVIDEND_WIDTH-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, result_ff.sample_rate_hz};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE:        if (entry_valid) state_in = BACK_DECODE;
         BACK_DECODE:      state_in = (status_c == STATUS_OK) ? BACK_MUL_RATE : BACK_DONE;
         BACK_MUL_RATE:    state_in = BACK_MUL_SAMPLES;
         BACK_MUL_SAMPLES: state_in = BACK_DIVIDE;
         BACK_DIVIDE:      if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = BACK_FRAME;
         BACK_FRAME:       state_in = BACK_DONE;
         BACK_DONE:        if (rsp_ready) state_in = BACK_IDLE;
         default:          state_in = BACK_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      pop       = (state_ff == BACK_IDLE) && entry_valid;
      rsp_valid = (state_ff == BACK_DONE);
      result    = result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BACK_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BACK_IDLE: begin
            if (entry_valid) entry_ff <= entry;
         end
         BACK_DECODE: begin
            result_ff <= decoded_c;
         end
         BACK_MUL_RATE: begin
            rate_prod_ff <= 19'(result_ff.bitrate_kbps) * 19'(KBPS_SCALE);
         end
         BACK_MUL_SAMPLES: begin
            result_ff.avg_bytes_per_sec <= 16'(rate_prod_ff >> 3);
            dividend_ff <= DIVIDEND_WIDTH'(30'(rate_prod_ff) * 30'(samples));
            rem_ff      <= '0;
            step_ff     <= '0;
         end
         BACK_DIVIDE: begin
            // One restoring step; quotient bits shift in behind the dividend.
            if (!trial[17]) begin
               rem_ff      <= trial[15:0];
               dividend_ff <= {dividend_ff[DIVIDEND_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff      <= rem_shift[15:0];
               dividend_ff <= {dividend_ff[DIVIDEND_WIDTH-2:0], 1'b0};
            end
            step_ff <= step_ff + STEP_W'(1);
         end
         BACK_FRAME: begin
            result_ff.frame_bytes <= 11'(dividend_ff >> 3) + 11'(result_ff.padding_bit);
         end
         BACK_DONE: begin
            result_ff <= result_ff;
         end
         default: begin
            result_ff <= result_ff;
         end
      endcase
   end

endmodule

// ===== hw/rtl/mp3_frame_header_finder_top.sv =====
// ----------------------------------------------------------------------------
// MP3 frame header finder
// Finds the first MPEG audio frame header of a file and reports its fields.
// ----------------------------------------------------------------------------
// The block takes an MP3 file one byte per transaction on the request channel,
// with stream_start on the first byte and stream_end on the last. A leading
// ID3v2 tag is measured and skipped, then a four-byte window slides over the
// bytes until frame sync is seen. Exactly one response transaction comes per
// file: either the decoded header or a status of no sync at the end of the
// file. Bytes after that response are dropped until the next stream_start.
// The scanner takes one byte per clock cycle and stalls only when its
// two-entry queue toward the decoder is full, which needs several files in a
// row ending faster than the decoder drains them. A valid header passes through
// the decoder (queue pop, decode, two multiplies, 29 steps of the bit-serial
// frame-length divide, final add) before the response shows; error and no-sync
// responses skip the arithmetic. The response is held in a register until it
// is taken, while the scanner keeps consuming bytes. Header positions count
// from zero in a POSITION_WIDTH-bit counter that saturates at all ones.
// ----------------------------------------------------------------------------
module mp3_frame_header_finder_top #(
   parameter int POSITION_WIDTH = mp3fhf_pkg::POSITION_WIDTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   mp3fhf_req_if.sink   req_ch,
   mp3fhf_rsp_if.source rsp_ch
);
   import mp3fhf_pkg::*;

   logic             in_accept;
   logic             push;
   entry_type        push_entry;
   logic             pop;
   entry_type        pop_entry;
   queue_status_type queue_status;
   result_type       result;

   // A byte is taken whenever the queue has room for what it might produce.
   assign req_ch.ready = !queue_status.full;
   assign in_accept    = req_ch.valid && req_ch.ready;

   mp3fhf_scan #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (in_accept),
      .data_byte    (req_ch.data_byte),
      .stream_start (req_ch.stream_start),
      .stream_end   (req_ch.stream_end),
      .push         (push),
      .push_entry   (push_entry)
   );

   mp3fhf_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_entry   (push_entry),
      .pop          (pop),
      .pop_entry    (pop_entry),
      .queue_status (queue_status)
   );

   mp3fhf_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (!queue_status.empty),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .result      (result)
   );

   // The response payload comes straight from the decoder's result register.
   assign rsp_ch.status            = result.status;
   assign rsp_ch.mpeg_version      = result.mpeg_version;
   assign rsp_ch.bitrate_kbps      = result.bitrate_kbps;
   assign rsp_ch.sample_rate_hz    = result.sample_rate_hz;
   assign rsp_ch.channel_count     = result.channel_count;
   assign rsp_ch.padding_bit       = result.padding_bit;
   assign rsp_ch.frame_bytes       = result.frame_bytes;
   assign rsp_ch.avg_bytes_per_sec = result.avg_bytes_per_sec;
   assign rsp_ch.tag_bytes         = result.tag_bytes;
   assign rsp_ch.header_position   = result.header_position;

endmodule

// ===== hw/rtl/mp3fhf_checker.sv =====
// ----------------------------------------------------------------------------
// MP3 frame header finder checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "mp3_frame_header_finder_top_macros.svh"

module mp3fhf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [1:0]  rsp_mpeg_version,
   input logic [8:0]  rsp_bitrate_kbps,
   input logic [10:0] rsp_frame_bytes,
   input logic [31:0] rsp_header_position
);
   import mp3fhf_pkg::*;

   `MP3FHF_ASSERT_AFTER_RESET(a_rsp_idle_after_reset, !rsp_valid, "response valid after reset")
   `MP3FHF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_header_position), "stalled response changed")
   `MP3FHF_ASSERT(a_err_fields_zero, rsp_valid && rsp_status != STATUS_OK, rsp_mpeg_version == VERSION_NONE && rsp_bitrate_kbps == 9'd0 && rsp_frame_bytes == 11'd0, "error response carries header fields")
   `MP3FHF_ASSERT(a_ok_version, rsp_valid && rsp_status == STATUS_OK, rsp_mpeg_version == VERSION_MPEG1 || rsp_mpeg_version == VERSION_MPEG2, "good response without a version")

endmodule

bind mp3_frame_header_finder_top mp3fhf_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_status          (rsp_ch.status),
   .rsp_mpeg_version    (rsp_ch.mpeg_version),
   .rsp_bitrate_kbps    (rsp_ch.bitrate_kbps),
   .rsp_frame_bytes     (rsp_ch.frame_bytes),
   .rsp_header_position (rsp_ch.header_position)
);
